/* rtl/range_min_update_point_query_top_defines.svh */
// assertion macros for the range minimum update / point query block
// used by range_min_update_point_query_top, no other dependencies
`ifndef RANGE_MIN_UPDATE_POINT_QUERY_TOP_DEFINES_SVH
`define RANGE_MIN_UPDATE_POINT_QUERY_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RMPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RMPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rmpq_pkg.sv */
// shared types and constants for the range minimum update / point query block
// no dependencies
`default_nettype none

package rmpq_pkg;

   localparam int VALUE_W = 31;
   localparam int INDEX_W = 10;
   localparam int POS_W   = 11;

   localparam logic [VALUE_W-1:0] EMPTY_VALUE = {VALUE_W{1'b1}};

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] range_low;
      logic [INDEX_W-1:0] range_high;
      logic [VALUE_W-1:0] update_value;
      logic [INDEX_W-1:0] point_index;
   } req_type;

   typedef struct packed {
      logic               strobe;
      logic               found;
      logic [VALUE_W-1:0] minimum;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/rmpq_engine.sv */
// tree engine: node tag memory, clearing pass, update walk and query walk
// depends on rmpq_pkg
`default_nettype none

module rmpq_engine import rmpq_pkg::*; #(
   parameter int POSITIONS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             start,
   input  wire logic [POS_W-1:0] positions,
   input  wire req_type          req,
   output logic                  busy,
   output rsp_type               rsp
);

   // tree of power-of-two leaves, root at 1, leaves at NP + index
   localparam int LB    = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int NP    = 1 << LB;
   localparam int AW    = LB + 1;
   localparam int DEPTH = 1 << AW;
   localparam int PW    = LB + 2;
   localparam int CW    = 18;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_UWALK = 3'd2;
   localparam logic [2:0] S_UWR   = 3'd3;
   localparam logic [2:0] S_QRD   = 3'd4;
   localparam logic [2:0] S_QACC  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [PW-1:0]      lp_ff, lp_in, rp_ff, rp_in;
   logic [AW-1:0]      tgt_ff, tgt_in;
   logic [AW-1:0]      node_ff, node_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   rsp_type            rsp_ff, rsp_in;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rdata_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [VALUE_W-1:0] mem_wdata;

   logic [CW-1:0]      a_ext, b_ext, idx_ext, pos_ext, b_clip;
   logic [PW-1:0]      rp_dec;
   logic [VALUE_W-1:0] acc_min;
   logic               upd_ok;

   // tag memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // request decode
   always_comb begin
      a_ext   = CW'(req.range_low);
      b_ext   = CW'(req.range_high);
      idx_ext = CW'(req.point_index);
      pos_ext = CW'(positions);
      b_clip  = (b_ext < pos_ext) ? b_ext : (pos_ext - CW'(1));
      upd_ok  = (a_ext <= b_ext) && (a_ext < pos_ext) && (req.update_value != EMPTY_VALUE);
      rp_dec  = rp_ff - PW'(1);
      acc_min = (rdata_ff < acc_ff) ? rdata_ff : acc_ff;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      lp_in     = lp_ff;
      rp_in     = rp_ff;
      tgt_in    = tgt_ff;
      node_in   = node_ff;
      val_in    = val_ff;
      acc_in    = acc_ff;
      rsp_in    = '{strobe: 1'b0, found: 1'b0, minimum: EMPTY_VALUE};
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = EMPTY_VALUE;
      mem_raddr = node_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req.command == CMD_UPDATE) begin
                  if (upd_ok) begin
                     lp_in    = PW'(a_ext) + PW'(NP);
                     rp_in    = PW'(b_clip) + PW'(NP) + PW'(1);
                     val_in   = req.update_value;
                     state_in = S_UWALK;
                  end
               end else if (idx_ext < pos_ext) begin
                  node_in  = AW'(idx_ext) + AW'(NP);
                  acc_in   = EMPTY_VALUE;
                  state_in = S_QRD;
               end else begin
                  rsp_in.strobe = 1'b1;
               end
            end
         end
         // bottom-up cover of the half-open leaf range [lp, rp)
         S_UWALK: begin
            if (lp_ff >= rp_ff) begin
               state_in = S_IDLE;
            end else if (lp_ff[0]) begin
               mem_raddr = lp_ff[AW-1:0];
               tgt_in    = lp_ff[AW-1:0];
               lp_in     = lp_ff + PW'(1);
               state_in  = S_UWR;
            end else if (rp_ff[0]) begin
               mem_raddr = rp_dec[AW-1:0];
               tgt_in    = rp_dec[AW-1:0];
               rp_in     = rp_dec;
               state_in  = S_UWR;
            end else begin
               lp_in = lp_ff >> 1;
               rp_in = rp_ff >> 1;
            end
         end
         // write back min of tag and value; next read is a different node
         S_UWR: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff;
            mem_wdata = (rdata_ff < val_ff) ? rdata_ff : val_ff;
            state_in  = S_UWALK;
         end
         S_QRD: begin
            mem_raddr = node_ff;
            state_in  = S_QACC;
         end
         // fold tags along the path from leaf to root
         S_QACC: begin
            acc_in = acc_min;
            if (node_ff == AW'(1)) begin
               rsp_in.strobe  = 1'b1;
               rsp_in.found   = (acc_min != EMPTY_VALUE);
               rsp_in.minimum = acc_min;
               state_in       = S_IDLE;
            end else begin
               node_in  = node_ff >> 1;
               state_in = S_QRD;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
      if (clear) begin
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         rsp_ff     <= '{strobe: 1'b0, found: 1'b0, minimum: EMPTY_VALUE};
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rsp_ff     <= rsp_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      lp_ff   <= lp_in;
      rp_ff   <= rp_in;
      tgt_ff  <= tgt_in;
      node_ff <= node_in;
      val_ff  <= val_in;
      acc_ff  <= acc_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/range_min_update_point_query_top.sv */
// query: reads and folds one node tag per tree level from leaf to root; the result is registered
// update: up to two covered nodes per level, each read and then written back, plus a shift per level;
//   a rejected update is never busy
// one transaction at a time; busy is set while the tag memory walk or a clearing pass runs
// reset and each write with paddr[2] low start a clearing pass over the whole tag memory
// result strobe lasts one cycle and cannot be held off by the receiver
`default_nettype none

`include "range_min_update_point_query_top_defines.svh"

module range_min_update_point_query_top import rmpq_pkg::*; #(
   parameter int POSITIONS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_command,
   input  wire logic [INDEX_W-1:0] req_range_low,
   input  wire logic [INDEX_W-1:0] req_range_high,
   input  wire logic [VALUE_W-1:0] req_update_value,
   input  wire logic [INDEX_W-1:0] req_point_index,
   output logic                    rsp_strobe,
   output logic                    rsp_found,
   output logic [VALUE_W-1:0]      rsp_minimum,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int LW = 18;
   localparam int POS_RESET = (POSITIONS < 1024) ? POSITIONS : 1024;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             cfg_wr;
   logic [LW-1:0]    wr_ext;
   req_type          req;
   rsp_type          rsp;

   // register write, limited to 1..POSITIONS
   always_comb begin
      cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
      wr_ext = LW'(pwdata[POS_W-1:0]);
      pos_in = pos_ff;
      if (cfg_wr) begin
         if (wr_ext == '0) begin
            pos_in = POS_W'(1);
         end else if (wr_ext > LW'(POSITIONS)) begin
            pos_in = POS_W'(POSITIONS);
         end else begin
            pos_in = pwdata[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_W'(POS_RESET);
      end else begin
         pos_ff <= pos_in;
      end
   end

   assign prdata = (paddr[2] == 1'b0) ? 32'(pos_ff) : 32'd0;
   assign pready = 1'b1;

   assign req = '{command: req_command, range_low: req_range_low,
                  range_high: req_range_high, update_value: req_update_value,
                  point_index: req_point_index};

   rmpq_engine #(
      .POSITIONS (POSITIONS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .clear     (cfg_wr),
      .start     (start && !busy),
      .positions (pos_ff),
      .req       (req),
      .busy      (busy),
      .rsp       (rsp)
   );

   assign rsp_strobe  = rsp.strobe;
   assign rsp_found   = rsp.found;
   assign rsp_minimum = rsp.minimum;

   // checks
   `RMPQ_ASSERT_NOW(a_empty_not_found, clock, reset, rsp_strobe && !rsp_found,
      rsp_minimum == EMPTY_VALUE, "empty result must read all ones")
   `RMPQ_ASSERT_NOW(a_found_not_empty, clock, reset, rsp_strobe && rsp_found,
      rsp_minimum != EMPTY_VALUE, "found result holds empty marker")
   `RMPQ_ASSERT_NEXT(a_write_clears, clock, reset, cfg_wr, busy,
      "register write did not start clearing pass")

endmodule

`default_nettype wire

/* verif/range_min_update_point_query_top_tb.sv */
// testbench for range_min_update_point_query_top: range chmin updates and point queries
// checked against a flat per-position minimum array; depends on rmpq_pkg and the rtl
`timescale 1ns / 1ps

class min_scoreboard;
   logic [30:0] expected_min[$];
   bit          expected_found[$];
   int          mismatch_count;
   int          unexpected_count;

   // note the result a query will give
   function void note_query(bit fnd, logic [30:0] mn);
      expected_found.insert(expected_found.size(), fnd);
      expected_min.insert(expected_min.size(), mn);
   endfunction

   // compare one result strobe with the oldest expectation
   function void check_result(bit fnd, logic [30:0] mn);
      bit          ef;
      logic [30:0] em;
      if (expected_min.size() == 0) begin
         unexpected_count++;
         if (mismatch_count + unexpected_count <= 10)
            $display("unexpected result found=%0d minimum=%0h", fnd, mn);
         return;
      end
      ef = expected_found.pop_front();
      em = expected_min.pop_front();
      if (ef !== fnd || em !== mn) begin
         mismatch_count++;
         if (mismatch_count + unexpected_count <= 10)
            $display("mismatch: expected found=%0d minimum=%0h, got found=%0d minimum=%0h",
                     ef, em, fnd, mn);
      end
   endfunction

   function int pending();
      return expected_min.size();
   endfunction
endclass

module range_min_update_point_query_top_tb;
   import rmpq_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_command = CMD_UPDATE;
   logic [INDEX_W-1:0] req_range_low = '0;
   logic [INDEX_W-1:0] req_range_high = '0;
   logic [VALUE_W-1:0] req_update_value = '0;
   logic [INDEX_W-1:0] req_point_index = '0;
   logic               rsp_strobe;
   logic               rsp_found;
   logic [VALUE_W-1:0] rsp_minimum;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   localparam logic [2:0] ADDR_POSITIONS = 3'd0;

   min_scoreboard board;
   logic [VALUE_W-1:0] position_min[1024];
   int                 live_positions;

   range_min_update_point_query_top uut (.*);

   always #4 clock = ~clock;

   // result monitor
   always @(posedge clock)
      if (!reset && rsp_strobe) board.check_result(rsp_found, rsp_minimum);

   // flat prediction of the tree
   function automatic void predict_update(int lo, int hi, logic [VALUE_W-1:0] v);
      if (lo > hi || lo >= live_positions || v == EMPTY_VALUE) return;
      if (hi >= live_positions) hi = live_positions - 1;
      for (int i = lo; i <= hi; i++)
         if (v < position_min[i]) position_min[i] = v;
   endfunction

   function automatic void predict_clear(logic [10:0] value);
      live_positions = (value == 0) ? 1 : (value > 1024 ? 1024 : value);
      for (int i = 0; i < 1024; i++) position_min[i] = EMPTY_VALUE;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      repeat (n) @(negedge clock);
   endtask

   // one transaction through the start/busy handshake
   task automatic send_item(bit cmd, int lo, int hi, logic [VALUE_W-1:0] v, int idx);
      @(negedge clock);
      req_command = cmd;
      req_range_low = INDEX_W'(lo);
      req_range_high = INDEX_W'(hi);
      req_update_value = v;
      req_point_index = INDEX_W'(idx);
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (cmd == CMD_QUERY) begin
         if (idx < live_positions && position_min[idx] != EMPTY_VALUE)
            board.note_query(1'b1, position_min[idx]);
         else
            board.note_query(1'b0, EMPTY_VALUE);
      end else begin
         predict_update(lo, hi, v);
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   // register write, only while idle
   task automatic write_positions(logic [31:0] value);
      while (board.pending() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      while (busy) @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; paddr = ADDR_POSITIONS; pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      predict_clear(value[10:0]);
   endtask

   task automatic random_item();
      int lo, hi, r;
      logic [VALUE_W-1:0] v;
      r = $urandom_range(0, 99);
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
      if (r < 70 && live_positions > 1) begin
         lo = $urandom_range(0, live_positions - 1);
         hi = $urandom_range(lo, live_positions - 1);
      end
      v = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, 255)) : VALUE_W'($urandom);
      if ($urandom_range(0, 30) == 0) v = EMPTY_VALUE;
      if ($urandom_range(0, 1))
         send_item(CMD_UPDATE, lo, hi, v, $urandom_range(0, 1023));
      else
         send_item(CMD_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   VALUE_W'($urandom),
                   (r < 80) ? $urandom_range(0, live_positions - 1) : $urandom_range(0, 1023));
      idle_gap();
   endtask

   initial begin
      int sizes[5];
      board = new();
      predict_clear(11'd1024);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // directed: extremes, empty queries, reversed and out of range updates
      send_item(CMD_QUERY, 0, 0, '0, 0);
      send_item(CMD_QUERY, 0, 0, '0, 1023);
      send_item(CMD_UPDATE, 0, 1023, 31'h7FFF_FFFE, 5);
      send_item(CMD_UPDATE, 10, 20, '0, 0);
      send_item(CMD_UPDATE, 30, 25, 31'd1, 0);
      send_item(CMD_UPDATE, 100, 200, EMPTY_VALUE, 0);
      send_item(CMD_UPDATE, 1023, 1023, 31'd7, 0);
      send_item(CMD_QUERY, 1023, 0, EMPTY_VALUE, 0);
      send_item(CMD_QUERY, 0, 0, '0, 15);
      send_item(CMD_QUERY, 0, 0, '0, 27);
      send_item(CMD_QUERY, 0, 0, '0, 1023);
      send_item(CMD_QUERY, 0, 0, '0, 512);
      write_positions(32'd0);
      send_item(CMD_UPDATE, 0, 1023, 31'd42, 0);
      send_item(CMD_QUERY, 0, 0, '0, 0);
      send_item(CMD_QUERY, 0, 0, '0, 1);
      write_positions(32'h0000_07FF);
      send_item(CMD_QUERY, 0, 0, '0, 1023);
      write_positions(32'd37);
      send_item(CMD_UPDATE, 30, 1023, 31'd9, 0);
      send_item(CMD_QUERY, 0, 0, '0, 36);
      send_item(CMD_QUERY, 0, 0, '0, 37);
      // random phases across several sizes
      sizes = '{1024, 1, 600, 2, 1000};
      foreach (sizes[k]) begin
         write_positions(sizes[k]);
         repeat (290) random_item();
      end
      while (board.pending() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (board.mismatch_count == 0 && board.unexpected_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
